/* rtl/bpc_pkg.sv */
// Shared types and constants for the barometric pressure and temperature compensation block.
// Holds the word formats, coefficient set, queue entry and register index codes.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int DT_W      = RAW_W + 1;
    localparam int TEMP_W    = 20;
    localparam int OFF_W     = 40;
    localparam int SENS_W    = 40;
    localparam int CORR_W    = 40;
    localparam int PRES_W    = 48;
    localparam int CFG_IDX_W = 3;

    localparam int QUEUE_DEPTH_DEF = 4;

    // First-order temperature thresholds in hundredths of a degree.
    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_COLD = -20'sd1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS        = 3'd0,
        REG_OFFSET      = 3'd1,
        REG_SENS_TEMP   = 3'd2,
        REG_OFFSET_TEMP = 3'd3,
        REG_REF_TEMP    = 3'd4,
        REG_TEMP_SLOPE  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] offset;
        logic [COEF_W-1:0] sens_temp;
        logic [COEF_W-1:0] offset_temp;
        logic [COEF_W-1:0] ref_temp;
        logic [COEF_W-1:0] temp_slope;
    } coeff_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } bpc_in_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_centi;
        logic signed [PRES_W-1:0] pressure_q15;
    } bpc_out_t;

    // One classified conversion pair waiting for the back end.
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [DT_W-1:0]   dt;
        logic signed [TEMP_W-1:0] temp1;
        logic                     cold;
        logic                     very_cold;
    } entry_t;

endpackage

/* rtl/bpc_front.sv */
// Front end: accepts conversion words, forms dT and the first-order temperature,
// and classifies each word by temperature range before it enters the queue.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_front
    import bpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  bpc_in_t                              sample,
    input  coeff_t                               coeff,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     queue_count,
    output logic                                 push,
    output entry_t                               push_entry
);

    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W   = CNT_W + 1;
    localparam int SLOPE_W = COEF_W + 1 + DT_W;

    logic                      a_valid_reg;
    logic                      b_valid_reg;
    logic [RAW_W-1:0]          a_d1_reg;
    logic [RAW_W-1:0]          b_d1_reg;
    logic signed [DT_W-1:0]    a_dt_reg;
    logic signed [DT_W-1:0]    b_dt_reg;
    logic signed [SLOPE_W-1:0] b_slope_reg;

    logic signed [DT_W-1:0]    dt_next;
    logic signed [SLOPE_W-1:0] slope_next;
    logic signed [TEMP_W-1:0]  temp1;
    logic [OCC_W-1:0]          occupancy;
    logic                      accept;

    // Words in the two front stages have a queue slot reserved for them,
    // so the front never has to stall once a word is taken.
    assign occupancy    = OCC_W'(queue_count) + OCC_W'(a_valid_reg) + OCC_W'(b_valid_reg);
    assign sample_ready = (occupancy < OCC_W'(QUEUE_DEPTH));
    assign accept       = sample_valid & sample_ready;

    assign dt_next = $signed({1'b0, sample.raw_temperature})
                   - $signed({1'b0, coeff.ref_temp, 8'h00});

    assign slope_next = SLOPE_W'($signed({1'b0, coeff.temp_slope})) * SLOPE_W'(a_dt_reg);

    assign temp1 = TEMP_REF + TEMP_W'(b_slope_reg >>> 23);

    always_comb
    begin
        push                 = b_valid_reg;
        push_entry.d1        = b_d1_reg;
        push_entry.dt        = b_dt_reg;
        push_entry.temp1     = temp1;
        push_entry.cold      = (temp1 < TEMP_REF);
        push_entry.very_cold = (temp1 < TEMP_COLD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_d1_reg    <= sample.raw_pressure;
        a_dt_reg    <= dt_next;
        b_d1_reg    <= a_d1_reg;
        b_dt_reg    <= a_dt_reg;
        b_slope_reg <= slope_next;
    end

    // The reservation scheme must never promise more slots than the queue has.
    assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= OCC_W'(QUEUE_DEPTH))
        else $error("front reserved more words than the queue can hold");

endmodule

/* rtl/bpc_queue.sv */
// Short first-in first-out queue of classified words between front and back end.
// Depends on bpc_pkg for the entry type.
`timescale 1ns / 1ps

module bpc_queue
    import bpc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  entry_t                         push_entry,
    input  logic                           pop,
    output entry_t                         head,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign head  = store_reg[rd_ptr_reg];
    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(DEPTH)))
        else $error("queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");

endmodule

/* rtl/bpc_back.sv */
// Back end: applies offset, sensitivity and second-order corrections and forms
// the Q15 pressure through an eight-stage pipeline ending in the output register.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_back
    import bpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  entry_t   head,
    output logic     pop,
    input  coeff_t   coeff,
    output logic     result_valid,
    input  logic     result_ready,
    output bpc_out_t result
);

    localparam int NUM_STAGES = 8;
    localparam int CPROD_W    = COEF_W + 1 + DT_W;
    localparam int DTSQ_W     = 2 * DT_W;
    localparam int SQ_W       = 2 * TEMP_W;
    localparam int SENS_LO_W  = 19;
    localparam int SENS_HI_W  = SENS_W - SENS_LO_W;
    localparam int PP_LO_W    = RAW_W + SENS_LO_W;
    localparam int PP_HI_W    = RAW_W + 1 + SENS_HI_W;
    localparam int PROD_W     = 64;

    localparam logic signed [CORR_W-1:0] CORR_ZERO = '0;

    typedef struct packed {
        logic [RAW_W-1:0]          d1;
        logic signed [TEMP_W-1:0]  temp1;
        logic                      cold;
        logic                      very_cold;
        logic signed [CPROD_W-1:0] off_prod;
        logic signed [CPROD_W-1:0] sens_prod;
        logic signed [DTSQ_W-1:0]  dtsq;
        logic signed [TEMP_W-1:0]  dlt;
        logic signed [TEMP_W-1:0]  ext;
    } s1_t;

    typedef struct packed {
        logic [RAW_W-1:0]          d1;
        logic signed [TEMP_W-1:0]  temp1;
        logic                      cold;
        logic                      very_cold;
        logic signed [OFF_W-1:0]   off1;
        logic signed [SENS_W-1:0]  sens1;
        logic signed [TEMP_W-1:0]  t2;
        logic signed [SQ_W-1:0]    dsq;
        logic signed [SQ_W-1:0]    esq;
    } s2_t;

    typedef struct packed {
        logic [RAW_W-1:0]          d1;
        logic signed [TEMP_W-1:0]  temp;
        logic                      cold;
        logic                      very_cold;
        logic signed [OFF_W-1:0]   off1;
        logic signed [SENS_W-1:0]  sens1;
        logic signed [CORR_W-1:0]  sq5;
        logic signed [CORR_W-1:0]  esq7;
        logic signed [CORR_W-1:0]  esq11;
    } s3_t;

    typedef struct packed {
        logic [RAW_W-1:0]          d1;
        logic signed [TEMP_W-1:0]  temp;
        logic                      cold;
        logic signed [OFF_W-1:0]   off1;
        logic signed [SENS_W-1:0]  sens1;
        logic signed [CORR_W-1:0]  off2;
        logic signed [CORR_W-1:0]  sens2;
    } s4_t;

    typedef struct packed {
        logic [RAW_W-1:0]          d1;
        logic signed [TEMP_W-1:0]  temp;
        logic signed [OFF_W-1:0]   off;
        logic signed [SENS_W-1:0]  sens;
    } s5_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0]  temp;
        logic signed [OFF_W-1:0]   off;
        logic [PP_LO_W-1:0]        pp_lo;
        logic signed [PP_HI_W-1:0] pp_hi;
    } s6_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0]  temp;
        logic signed [OFF_W-1:0]   off;
        logic signed [PROD_W-1:0]  prod;
    } s7_t;

    logic [NUM_STAGES-1:0] valid_reg;
    logic                  adv;

    s1_t      s1_reg, s1_next;
    s2_t      s2_reg, s2_next;
    s3_t      s3_reg, s3_next;
    s4_t      s4_reg, s4_next;
    s5_t      s5_reg, s5_next;
    s6_t      s6_reg, s6_next;
    s7_t      s7_reg, s7_next;
    bpc_out_t out_reg, out_next;

    // The whole pipe moves together unless a finished word is held at the output.
    assign adv = !valid_reg[NUM_STAGES-1] || result_ready;
    assign pop = adv && head_valid;

    // Stage 1: first-order products and the distances from both thresholds.
    always_comb
    begin
        s1_next.d1        = head.d1;
        s1_next.temp1     = head.temp1;
        s1_next.cold      = head.cold;
        s1_next.very_cold = head.very_cold;
        s1_next.off_prod  = CPROD_W'($signed({1'b0, coeff.offset_temp})) * CPROD_W'(head.dt);
        s1_next.sens_prod = CPROD_W'($signed({1'b0, coeff.sens_temp})) * CPROD_W'(head.dt);
        s1_next.dtsq      = DTSQ_W'(head.dt) * DTSQ_W'(head.dt);
        s1_next.dlt       = head.temp1 - TEMP_REF;
        s1_next.ext       = head.temp1 - TEMP_COLD;
    end

    // Stage 2: first-order offset and sensitivity, T2 and the squared distances.
    always_comb
    begin
        s2_next.d1        = s1_reg.d1;
        s2_next.temp1     = s1_reg.temp1;
        s2_next.cold      = s1_reg.cold;
        s2_next.very_cold = s1_reg.very_cold;
        s2_next.off1      = OFF_W'($signed({1'b0, coeff.offset, 16'h0000}))
                          + OFF_W'(s1_reg.off_prod >>> 7);
        s2_next.sens1     = SENS_W'($signed({1'b0, coeff.sens, 15'h0000}))
                          + SENS_W'(s1_reg.sens_prod >>> 8);
        s2_next.t2        = TEMP_W'(s1_reg.dtsq >>> 31);
        s2_next.dsq       = SQ_W'(s1_reg.dlt) * SQ_W'(s1_reg.dlt);
        s2_next.esq       = SQ_W'(s1_reg.ext) * SQ_W'(s1_reg.ext);
    end

    // Stage 3: constant multiples by shift and add, and the final temperature.
    always_comb
    begin
        s3_next.d1        = s2_reg.d1;
        s3_next.temp      = s2_reg.cold ? (s2_reg.temp1 - s2_reg.t2) : s2_reg.temp1;
        s3_next.cold      = s2_reg.cold;
        s3_next.very_cold = s2_reg.very_cold;
        s3_next.off1      = s2_reg.off1;
        s3_next.sens1     = s2_reg.sens1;
        s3_next.sq5       = (CORR_W'(s2_reg.dsq) <<< 2) + CORR_W'(s2_reg.dsq);
        s3_next.esq7      = (CORR_W'(s2_reg.esq) <<< 3) - CORR_W'(s2_reg.esq);
        s3_next.esq11     = (CORR_W'(s2_reg.esq) <<< 3) + (CORR_W'(s2_reg.esq) <<< 1)
                          + CORR_W'(s2_reg.esq);
    end

    // Stage 4: second-order offset and sensitivity terms; the extra term only
    // applies below minus fifteen degrees.
    always_comb
    begin
        s4_next.d1    = s3_reg.d1;
        s4_next.temp  = s3_reg.temp;
        s4_next.cold  = s3_reg.cold;
        s4_next.off1  = s3_reg.off1;
        s4_next.sens1 = s3_reg.sens1;
        s4_next.off2  = (s3_reg.sq5 >>> 1)
                      + (s3_reg.very_cold ? s3_reg.esq7 : CORR_ZERO);
        s4_next.sens2 = (s3_reg.sq5 >>> 2)
                      + (s3_reg.very_cold ? (s3_reg.esq11 >>> 1) : CORR_ZERO);
    end

    // Stage 5: corrected offset and sensitivity.
    always_comb
    begin
        s5_next.d1   = s4_reg.d1;
        s5_next.temp = s4_reg.temp;
        s5_next.off  = s4_reg.cold ? (s4_reg.off1 - OFF_W'(s4_reg.off2)) : s4_reg.off1;
        s5_next.sens = s4_reg.cold ? (s4_reg.sens1 - SENS_W'(s4_reg.sens2)) : s4_reg.sens1;
    end

    // Stage 6: D1 times SENS as two partial products on the split sensitivity.
    always_comb
    begin
        s6_next.temp  = s5_reg.temp;
        s6_next.off   = s5_reg.off;
        s6_next.pp_lo = PP_LO_W'(s5_reg.d1) * PP_LO_W'(s5_reg.sens[SENS_LO_W-1:0]);
        s6_next.pp_hi = PP_HI_W'($signed({1'b0, s5_reg.d1}))
                      * PP_HI_W'($signed(s5_reg.sens[SENS_W-1:SENS_LO_W]));
    end

    // Stage 7: partial products recombined.
    always_comb
    begin
        s7_next.temp = s6_reg.temp;
        s7_next.off  = s6_reg.off;
        s7_next.prod = (PROD_W'(s6_reg.pp_hi) <<< SENS_LO_W) + PROD_W'(s6_reg.pp_lo);
    end

    // Stage 8: scaled pressure minus offset, into the output register.
    always_comb
    begin
        out_next.temperature_centi = s7_reg.temp;
        out_next.pressure_q15      = PRES_W'((s7_reg.prod >>> 21) - PROD_W'(s7_reg.off));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            s5_reg  <= s5_next;
            s6_reg  <= s6_next;
            s7_reg  <= s7_next;
            out_reg <= out_next;
        end
    end

    assign result_valid = valid_reg[NUM_STAGES-1];
    assign result       = out_reg;

    // A held output freezes every stage, so no word in flight may vanish or appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipeline moved while the output was stalled");

endmodule

/* rtl/baro_pressure_temp_compensation_top.sv */
// Barometric pressure and temperature compensation, second-order scheme.
// Throughput: one word per cycle while result_ready is high; each product is registered.
// Reset (rst_n low, asynchronous) clears all valid bits, the queue and the six coefficients.
// Depends on bpc_pkg, bpc_front, bpc_queue and bpc_back.
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_top
    import bpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  bpc_in_t              sample,
    output logic                 result_valid,
    input  logic                 result_ready,
    output bpc_out_t             result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    coeff_t            coeff_reg;
    coeff_t            coeff_next;
    logic              push;
    entry_t            push_entry;
    logic              pop;
    entry_t            head;
    logic [CNT_W-1:0]  queue_count;
    logic              head_valid;

    // The coefficient registers accept a write in every cycle. Writes to an
    // index beyond the six coefficients are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        coeff_next = coeff_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SENS:        coeff_next.sens        = cfg_data;
                REG_OFFSET:      coeff_next.offset      = cfg_data;
                REG_SENS_TEMP:   coeff_next.sens_temp   = cfg_data;
                REG_OFFSET_TEMP: coeff_next.offset_temp = cfg_data;
                REG_REF_TEMP:    coeff_next.ref_temp    = cfg_data;
                REG_TEMP_SLOPE:  coeff_next.temp_slope  = cfg_data;
                default:         coeff_next             = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

    // The front takes a word whenever the queue plus its own two stages
    // have room, computes dT and the first-order temperature, and tags the
    // word as cold (below 20.00 C) and very cold (below -15.00 C).
    bpc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .coeff        (coeff_reg),
        .queue_count  (queue_count),
        .push         (push),
        .push_entry   (push_entry)
    );

    // The queue lets the front keep taking words while the back end is
    // held by a stalled result.
    bpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .count      (queue_count)
    );

    assign head_valid = (queue_count != '0);

    // The back end applies offset, sensitivity and the second-order
    // corrections and delivers the result from its output register.
    bpc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .coeff        (coeff_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the barometric pressure and temperature compensation block.
// Predicts each compensated reading in 64-bit integer arithmetic and checks it field by field.
// Depends on bpc_pkg and baro_pressure_temp_compensation_top.
`timescale 1ns / 1ps

module testbench;
    import bpc_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 11;
    localparam int LATENCY      = 10;
    localparam int SETTLE       = LATENCY + 4;
    localparam int QUIET_LIMIT  = 3000;
    localparam int REPORT_MAX   = 20;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 50;

    // Shift amounts of the compensation scheme.
    localparam int SLOPE_SH  = 23;
    localparam int OFFT_SH   = 7;
    localparam int SENST_SH  = 8;
    localparam int T2_SH     = 31;
    localparam int PRES_SH   = 21;
    localparam int REFT_SH   = 8;
    localparam int OFF_SH    = 16;
    localparam int SENS_SH   = 15;

    // Indexes past the last coefficient; writes to them must leave the set unchanged.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [RAW_W-1:0]  RAW_MAX  = {RAW_W{1'b1}};
    localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    bpc_in_t              sample = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    bpc_out_t             result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data = '0;

    // Conversion pairs waiting to be sent, and readings predicted for accepted pairs.
    bpc_in_t  raw_pairs[$];
    bpc_out_t predicted_readings[$];

    // Our copy of the coefficient registers, updated on every accepted write.
    coeff_t coeffs = '0;

    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatch_count = 0;
    bit          idle_on = 1'b0;
    bit          stall_on = 1'b0;
    logic        sample_taken = 1'b0;
    logic        reading_taken;
    logic        cfg_taken;

    baro_pressure_temp_compensation_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Compensated temperature and pressure for one conversion pair. Every intermediate
    // of the scheme fits in 64 bits, and >>> on a signed longint rounds toward minus
    // infinity, which is exactly the floor that the scheme asks for. The coefficients
    // are widened as signed values so that every shift stays arithmetic.
    function automatic bpc_out_t compensate(bpc_in_t s, coeff_t k);
        longint d1, d2, dt, temp, off, sens, t2, dlt, sq5, off2, sens2, e, esq, p;
        bpc_out_t r;
        d1 = {40'd0, s.raw_pressure};
        d2 = {40'd0, s.raw_temperature};
        dt = d2 - (longint'({48'd0, k.ref_temp}) << REFT_SH);
        temp = longint'(TEMP_REF) + ((longint'({48'd0, k.temp_slope}) * dt) >>> SLOPE_SH);
        off = (longint'({48'd0, k.offset}) << OFF_SH)
            + ((longint'({48'd0, k.offset_temp}) * dt) >>> OFFT_SH);
        sens = (longint'({48'd0, k.sens}) << SENS_SH)
             + ((longint'({48'd0, k.sens_temp}) * dt) >>> SENST_SH);
        // Second-order correction below the reference temperature, with an
        // extra term once the first-order temperature is in the very cold band.
        if (temp < longint'(TEMP_REF))
        begin
            t2 = (dt * dt) >>> T2_SH;
            dlt = temp - longint'(TEMP_REF);
            sq5 = 64'sd5 * dlt * dlt;
            off2 = sq5 >>> 1;
            sens2 = sq5 >>> 2;
            if (temp < longint'(TEMP_COLD))
            begin
                e = temp - longint'(TEMP_COLD);
                esq = e * e;
                off2 = off2 + 64'sd7 * esq;
                sens2 = sens2 + ((64'sd11 * esq) >>> 1);
            end
            temp = temp - t2;
            off = off - off2;
            sens = sens - sens2;
        end
        p = ((d1 * sens) >>> PRES_SH) - off;
        r.temperature_centi = temp[TEMP_W-1:0];
        r.pressure_q15 = p[PRES_W-1:0];
        return r;
    endfunction

    // Mostly no gap, some short ones and a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A random pair. Raw temperatures cluster around the reference point at a random
    // scale, so the warm, cold and very cold bands all come up under most settings.
    function automatic bpc_in_t random_pair(coeff_t k);
        bpc_in_t s;
        int unsigned r;
        int unsigned span;
        longint c, o, v;
        r = $urandom_range(0, 9);
        if (r == 0)
            s.raw_pressure = '0;
        else if (r == 1)
            s.raw_pressure = RAW_MAX;
        else
            s.raw_pressure = RAW_W'($urandom());
        if ($urandom_range(0, 9) < 4)
            s.raw_temperature = RAW_W'($urandom());
        else
        begin
            c = {48'd0, k.ref_temp} << REFT_SH;
            span = $urandom_range(2, RAW_W);
            o = longint'($urandom_range(0, (1 << span) - 1));
            if ($urandom_range(0, 1))
                o = -o;
            v = c + o;
            if (v < 0)
                v = 0;
            if (v > longint'({40'd0, RAW_MAX}))
                v = {40'd0, RAW_MAX};
            s.raw_temperature = v[RAW_W-1:0];
        end
        return s;
    endfunction

    function automatic logic [COEF_W-1:0] random_coeff();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return COEF_MAX;
        return COEF_W'($urandom());
    endfunction

    task automatic push_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        bpc_in_t s;
        s.raw_pressure = d1;
        s.raw_temperature = d2;
        raw_pairs.push_back(s);
    endtask

    // One register write. The valid is left high so that back-to-back writes
    // keep the channel busy; load_coeffs lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SENS:        coeffs.sens = val;
            REG_OFFSET:      coeffs.offset = val;
            REG_SENS_TEMP:   coeffs.sens_temp = val;
            REG_OFFSET_TEMP: coeffs.offset_temp = val;
            REG_REF_TEMP:    coeffs.ref_temp = val;
            REG_TEMP_SLOPE:  coeffs.temp_slope = val;
            default:         ;
        endcase
    endtask

    task automatic load_coeffs(input coeff_t k, input bit spare);
        write_reg(REG_SENS, k.sens);
        write_reg(REG_OFFSET, k.offset);
        write_reg(REG_SENS_TEMP, k.sens_temp);
        write_reg(REG_OFFSET_TEMP, k.offset_temp);
        write_reg(REG_REF_TEMP, k.ref_temp);
        write_reg(REG_TEMP_SLOPE, k.temp_slope);
        if (spare)
        begin
            write_reg(REG_SPARE_LO, COEF_W'($urandom()));
            write_reg(REG_SPARE_HI, COEF_W'($urandom()));
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued pair has gone in and every predicted reading has come
    // out, then lets the pipeline latency pass so the block is idle for a write.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (raw_pairs.size() != 0 || sample_valid || predicted_readings.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Sender. A new word goes out only once the previous one is accepted and its
    // gap has run out; otherwise the word on the port is held as it is.
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else if (!sample_valid || sample_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                sample_valid <= 1'b0;
            end
            else if (raw_pairs.size() > 0)
            begin
                sample <= raw_pairs.pop_front();
                sample_valid <= 1'b1;
                send_gap = idle_on ? pick_gap() : 0;
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // Receiver back-pressure: random stalls, none at all in some phases.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            if (stall_on && $urandom_range(0, 4) == 0)
                stall_left = pick_gap();
        end
    end

    // Handshakes are seen at the rising edge. An accepted pair gets its prediction
    // from the current coefficients; an accepted reading is checked against the
    // oldest prediction. The watchdog ends the run if nothing moves for too long.
    always @(posedge clk)
    begin
        sample_taken = rst_n && sample_valid && sample_ready;
        reading_taken = rst_n && result_valid && result_ready;
        cfg_taken = rst_n && cfg_valid && cfg_ready;
        if (sample_taken)
            predicted_readings.push_back(compensate(sample, coeffs));
        if (reading_taken)
        begin
            if (predicted_readings.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_MAX)
                    $error("reading with no pair outstanding: temperature_centi %0d",
                           result.temperature_centi);
            end
            else
            begin
                bpc_out_t want;
                want = predicted_readings.pop_front();
                if (result.temperature_centi !== want.temperature_centi)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_MAX)
                        $error("temperature_centi: expected %0d, actual %0d",
                               want.temperature_centi, result.temperature_centi);
                end
                if (result.pressure_q15 !== want.pressure_q15)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_MAX)
                        $error("pressure_q15: expected %0d, actual %0d",
                               want.pressure_q15, result.pressure_q15);
                end
            end
        end
        if (sample_taken || reading_taken || cfg_taken)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        coeff_t k;
        logic [RAW_W-1:0] tref;
        int p;
        int n;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Coefficients straight out of reset are all zero and used as they are.
        push_pair('0, '0);
        push_pair(RAW_MAX, RAW_MAX);
        push_pair(RAW_MAX, '0);
        wait_drained();

        // A typical factory calibration, with writes to the spare indexes that
        // must be ignored. Raw temperatures land at the reference point, just
        // below it (cold), deep below it (very cold), and at both range ends.
        k.sens = 16'd40127;
        k.offset = 16'd36924;
        k.sens_temp = 16'd23317;
        k.offset_temp = 16'd23282;
        k.ref_temp = 16'd33464;
        k.temp_slope = 16'd28312;
        load_coeffs(k, 1'b1);
        tref = {k.ref_temp, 8'd0};
        push_pair(24'd9085466, tref);
        push_pair(24'd9085466, tref - 24'd1);
        push_pair(24'd9085466, tref + 24'd1);
        push_pair(RAW_MAX, tref - 24'd1200000);
        push_pair('0, tref - 24'd1200000);
        push_pair(RAW_MAX, '0);
        push_pair(RAW_MAX, RAW_MAX);
        push_pair(24'd6000000, tref - 24'd400000);
        wait_drained();

        // Every coefficient at full scale.
        load_coeffs('{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX}, 1'b0);
        push_pair(RAW_MAX, '0);
        push_pair(RAW_MAX, RAW_MAX);
        push_pair('0, '0);
        push_pair(RAW_MAX, {COEF_MAX, 8'd0});
        wait_drained();

        // Random phases: all zero written back, all full scale, then random sets.
        // One phase runs with no idling on either side.
        for (p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 0)
                k = '0;
            else if (p == 1)
                k = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX};
            else
            begin
                k.sens = random_coeff();
                k.offset = random_coeff();
                k.sens_temp = random_coeff();
                k.offset_temp = random_coeff();
                k.ref_temp = random_coeff();
                k.temp_slope = random_coeff();
            end
            load_coeffs(k, p % 4 == 2);
            idle_on = (p % 3 != 1);
            stall_on = (p % 4 != 3);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                raw_pairs.push_back(random_pair(coeffs));
                // Halfway through one phase the sender holds off until every
                // outstanding reading is back, then carries on.
                if (p == 5 && n == PHASE_ITEMS / 2)
                    wait_drained();
            end
            wait_drained();
        end

        // A reading still predicted here would have tripped the watchdog, but a
        // leftover is counted anyway before the verdict.
        if (predicted_readings.size() != 0)
            mismatch_count = mismatch_count + 1;
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
